### rtl/psgc_pkg.sv
// Package for the pulse integrator: field types, widths, bin codes and
// configuration register indexes. No dependencies; every other file imports it.
`default_nettype none

package psgc_pkg;

  // ADC sample width and the window length it is summed over.
  localparam int SAMPLE_BITS    = 12;
  localparam int WINDOW_BINS    = 8;
  localparam int BIN_BITS       = $clog2(WINDOW_BINS);
  localparam int SUM_BITS       = SAMPLE_BITS + BIN_BITS;

  // Register and result widths fixed by the field list.
  localparam int PED_BITS       = 15;
  localparam int GAIN_BITS      = 10;
  localparam int GAIN_FRAC_BITS = 6;
  localparam int ENERGY_BITS    = 19;
  localparam int CFG_DATA_BITS  = (PED_BITS > GAIN_BITS) ? PED_BITS : GAIN_BITS;

  // Internal arithmetic widths.
  localparam int DIFF_BITS      = (SUM_BITS > PED_BITS) ? SUM_BITS : PED_BITS;
  localparam int PROD_BITS      = SUM_BITS + GAIN_BITS;
  localparam int SCALED_BITS    = PROD_BITS - GAIN_FRAC_BITS;
  localparam int CMP_BITS       = (SCALED_BITS > ENERGY_BITS) ? SCALED_BITS : ENERGY_BITS;

  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic [BIN_BITS-1:0]      time_bin_t;
  typedef logic [SUM_BITS-1:0]      sum_t;
  typedef logic [PED_BITS-1:0]      pedestal_t;
  typedef logic [GAIN_BITS-1:0]     gain_t;
  typedef logic [ENERGY_BITS-1:0]   energy_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;
  typedef logic [1:0]               peak_flags_t;

  localparam sum_t      SUM_MAX     = '1;
  localparam energy_t   ENERGY_MAX  = '1;
  localparam gain_t     GAIN_UNITY  = gain_t'(1 << GAIN_FRAC_BITS);

  // Time bin codes with a special meaning.
  localparam time_bin_t BIN_START   = time_bin_t'(0);
  localparam time_bin_t BIN_REF     = time_bin_t'(2);
  localparam time_bin_t BIN_PEAK    = time_bin_t'(3);
  localparam time_bin_t BIN_FALL    = time_bin_t'(4);
  localparam time_bin_t BIN_LAST    = time_bin_t'(WINDOW_BINS - 1);

  // Peak flag patterns.
  localparam peak_flags_t FLAG_RISE = 2'b01;
  localparam peak_flags_t FLAG_FALL = 2'b10;
  localparam peak_flags_t FLAG_PEAK = 2'b11;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_PEDESTAL = 1'b0,
    CFG_GAIN     = 1'b1
  } cfg_idx_t;

endpackage

`default_nettype wire

### rtl/psgc_if.sv
// Valid/ready channel interfaces for the pulse integrator: sample input,
// energy result and configuration write. Depends on psgc_pkg.
`default_nettype none

interface psgc_in_if import psgc_pkg::*; ();
  logic      valid;
  logic      ready;
  sample_t   sample;
  time_bin_t time_bin;

  modport source (output valid, sample, time_bin, input ready);
  modport sink   (input valid, sample, time_bin, output ready);
endinterface

interface psgc_out_if import psgc_pkg::*; ();
  logic    valid;
  logic    ready;
  energy_t energy;
  logic    valid_res;

  modport source (output valid, energy, valid_res, input ready);
  modport sink   (input valid, energy, valid_res, output ready);
endinterface

interface psgc_cfg_if import psgc_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/pulse_sum_peak_gain_correct.sv
// Top level of the pulse integrator with pedestal subtraction, gain
// correction and peak check. Depends on psgc_pkg and the psgc_if interfaces.
`default_nettype none

// Takes one ADC sample per beat, tagged with its time bin, and returns one
// result beat for every sample beat, in order. Bin 0 restarts the window sum
// and clears the peak flags; every other bin adds its sample with saturation.
// A peak is a bin 3 sample not below bin 2 followed by a bin 4 sample below
// bin 3. On bin 7 with a peak, energy = sat((max(sum - pedestal, 0) * gain)
// >> 6) and valid_res = 1; every other beat returns energy 0, valid_res 0.
// Rate: one sample beat per cycle, sustained, while the result side keeps
// up. The window state updates in the accept cycle and lands in the input
// register, then the pedestal subtraction, the 15 x 10 gain multiply and
// the saturation run in one pass into the output register that drives
// out_bus. Stalls ripple back from out_bus.ready, so in_bus.ready drops
// only when both registers are full.
// Configuration: index 0 = pedestal (15 bits, reset 0), index 1 = gain
// (10 bits, unsigned 4.6, reset 64 = 1.0). cfg_bus is always ready; write
// only while no result is pending.
module pulse_sum_peak_gain_correct
  import psgc_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  psgc_in_if.sink      in_bus,
  psgc_out_if.source   out_bus,
  psgc_cfg_if.sink     cfg_bus
);

  // Configuration registers.
  pedestal_t   pedestal_r;
  gain_t       gain_r;

  // Window state.
  sum_t        window_sum_r, window_sum_nxt;
  peak_flags_t peak_flags_r, peak_flags_nxt;
  sample_t     prev_sample_r, prev_sample_nxt;

  // Stage 1: updated sum and hit flag.
  logic        s1_v_r;
  logic        s1_hit_r, s1_hit_nxt;
  sum_t        s1_sum_r;

  // Stage 2: output register.
  logic        out_v_r;
  logic        out_hit_r;
  energy_t     out_energy_r, out_energy_nxt;

  logic        s2_ready, s1_ready;
  logic        in_fire;

  logic [SUM_BITS:0]      add_full;
  sum_t                   add_sat;
  logic [DIFF_BITS-1:0]   sum_x, ped_x;
  sum_t                   net_sum;
  logic [PROD_BITS-1:0]   product;
  logic [SCALED_BITS-1:0] scaled;
  logic [CMP_BITS-1:0]    scaled_x;

  // Ready chain: a stage takes a new beat when empty or when it drains.
  assign s2_ready     = !out_v_r || out_bus.ready;
  assign s1_ready     = !s1_v_r || s2_ready;
  assign in_bus.ready = s1_ready;
  assign in_fire      = in_bus.valid && s1_ready;

  assign cfg_bus.ready = 1'b1;

  // Window state update: one saturating add and one compare.
  always_comb begin
    add_full        = {1'b0, window_sum_r} + (SUM_BITS + 1)'(in_bus.sample);
    add_sat         = add_full[SUM_BITS] ? SUM_MAX : add_full[SUM_BITS-1:0];
    window_sum_nxt  = add_sat;
    peak_flags_nxt  = peak_flags_r;
    prev_sample_nxt = prev_sample_r;
    unique case (in_bus.time_bin)
      BIN_START: begin
        // restart the window
        window_sum_nxt  = SUM_BITS'(in_bus.sample);
        peak_flags_nxt  = '0;
        prev_sample_nxt = '0;
      end
      BIN_REF: begin
        prev_sample_nxt = in_bus.sample;
      end
      BIN_PEAK: begin
        // rising edge resets the flags to rise only
        if (in_bus.sample >= prev_sample_r) begin
          peak_flags_nxt = FLAG_RISE;
        end
        prev_sample_nxt = in_bus.sample;
      end
      BIN_FALL: begin
        if (in_bus.sample < prev_sample_r) begin
          peak_flags_nxt = peak_flags_r | FLAG_FALL;
        end
      end
      default: begin
      end
    endcase
    s1_hit_nxt = (in_bus.time_bin == BIN_LAST) && (peak_flags_nxt == FLAG_PEAK);
  end

  // Pedestal subtraction clamped at zero, gain multiply, drop the fraction,
  // saturate to the result width; a beat without a peak gets zero.
  always_comb begin
    sum_x    = DIFF_BITS'(s1_sum_r);
    ped_x    = DIFF_BITS'(pedestal_r);
    net_sum  = (sum_x > ped_x) ? SUM_BITS'(sum_x - ped_x) : '0;
    product  = PROD_BITS'(net_sum) * PROD_BITS'(gain_r);
    scaled   = product[PROD_BITS-1:GAIN_FRAC_BITS];
    scaled_x = CMP_BITS'(scaled);
    if (!s1_hit_r) begin
      out_energy_nxt = '0;
    end else if (scaled_x > CMP_BITS'(ENERGY_MAX)) begin
      out_energy_nxt = ENERGY_MAX;
    end else begin
      out_energy_nxt = ENERGY_BITS'(scaled_x);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pedestal_r <= '0;
      gain_r     <= GAIN_UNITY;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_PEDESTAL: pedestal_r <= PED_BITS'(cfg_bus.data);
        CFG_GAIN:     gain_r     <= cfg_bus.data[GAIN_BITS-1:0];
        default:      ;
      endcase
    end
  end

  // Window state: advance on every accepted sample beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_sum_r  <= '0;
      peak_flags_r  <= '0;
      prev_sample_r <= '0;
    end else if (in_fire) begin
      window_sum_r  <= window_sum_nxt;
      peak_flags_r  <= peak_flags_nxt;
      prev_sample_r <= prev_sample_nxt;
    end
  end

  // Pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_bus.valid;
      end
      if (s2_ready) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Pipeline payload: hold while the stage is stalled.
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_sum_r <= window_sum_nxt;
      s1_hit_r <= s1_hit_nxt;
    end
    if (s2_ready) begin
      out_energy_r <= out_energy_nxt;
      out_hit_r    <= s1_hit_r;
    end
  end

  assign out_bus.valid     = out_v_r;
  assign out_bus.energy    = out_energy_r;
  assign out_bus.valid_res = out_hit_r;

`ifndef SYNTH
  // A result without a peak carries zero energy.
  a_no_peak_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.valid_res |-> out_bus.energy == '0)
    else $error("energy non-zero on a result without a peak");

  // Bin 0 clears the peak history.
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_bus.time_bin == BIN_START |=> peak_flags_r == '0 && prev_sample_r == '0)
    else $error("window restart did not clear peak state");

  // Within a window the sum never falls.
  a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_bus.time_bin != BIN_START |=> window_sum_r >= $past(window_sum_r))
    else $error("window sum decreased inside a window");

  // An accepted beat always lands in stage 1.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_v_r)
    else $error("accepted sample beat lost at stage 1");
`endif

endmodule

`default_nettype wire

### verif/pulse_sum_peak_gain_correct_test.sv
// Self-checking testbench for pulse_sum_peak_gain_correct: directed and random
// sample windows with checked energy beats. Depends on psgc_pkg, the psgc_if
// interfaces and the block's RTL.
module pulse_sum_peak_gain_correct_test;
  import psgc_pkg::*;

  // Idle cycles with no beat on any channel before the run is abandoned.
  localparam int IDLE_LIMIT       = 2000;
  // Quiet cycles after the last result; the block's pipeline is two deep.
  localparam int DRAIN_CYCLES     = 8;
  localparam int SHOWN_MISMATCHES = 10;
  // Well-formed windows per configuration phase; noise bursts are mixed in.
  localparam int PHASE_WINDOWS    = 28;
  localparam int RANDOM_PHASES    = 5;

  localparam sample_t SAMPLE_FULL = '1;

  typedef struct packed {
    sample_t   sample;
    time_bin_t time_bin;
  } adc_beat_t;

  typedef struct packed {
    energy_t energy;
    logic    valid_res;
  } energy_beat_t;

  logic clk;
  logic rst_n;

  psgc_in_if  in_if ();
  psgc_out_if out_if ();
  psgc_cfg_if cfg_if ();

  pulse_sum_peak_gain_correct dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  // Sample beats waiting for the driver, and energy beats still owed by the block.
  adc_beat_t    pending_beats [$];
  energy_beat_t expected_energy [$];
  int           beats_queued;
  int           beats_taken;

  // Integrator state, advanced on every accepted sample beat, and register copies.
  sum_t        win_sum;
  peak_flags_t win_flags;
  sample_t     win_prev;
  pedestal_t   ped_now;
  gain_t       gain_now;

  int mismatches;
  bit idling_on;
  int in_gap;
  int out_stall;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap or stall length: mostly short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic sample_t rand_sample(input int unsigned top);
    return sample_t'($urandom_range(0, top));
  endfunction

  // Advance the window state by one sample and return the energy beat it
  // causes: sum with saturation, rise at bin 3, fall at bin 4, report at bin 7.
  function automatic energy_beat_t integrate_sample(input sample_t smp, input time_bin_t tbin);
    energy_beat_t         res;
    logic [SUM_BITS:0]    wide_sum;
    logic [DIFF_BITS-1:0] net;
    logic [PROD_BITS-1:0] product;
    logic [PROD_BITS-1:0] scaled;
    res = '0;
    wide_sum = {1'b0, win_sum} + smp;
    if (tbin == BIN_START) begin
      win_sum   = sum_t'(smp);
      win_flags = '0;
      win_prev  = '0;
    end else begin
      win_sum = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[SUM_BITS-1:0];
      if (tbin == BIN_REF) begin
        win_prev = smp;
      end else if (tbin == BIN_PEAK) begin
        // a bin 3 that does not rise leaves the flags alone
        if (smp >= win_prev) win_flags = FLAG_RISE;
        win_prev = smp;
      end else if (tbin == BIN_FALL && smp < win_prev) begin
        win_flags = win_flags | FLAG_FALL;
      end
    end
    if (tbin == BIN_LAST && win_flags == FLAG_PEAK) begin
      net     = (win_sum > ped_now) ? DIFF_BITS'(win_sum - ped_now) : '0;
      product = net * gain_now;
      scaled  = product >> GAIN_FRAC_BITS;
      res.energy    = (scaled > ENERGY_MAX) ? ENERGY_MAX : scaled[ENERGY_BITS-1:0];
      res.valid_res = 1'b1;
    end
    return res;
  endfunction

  task automatic push_beat(input sample_t smp, input time_bin_t tbin);
    adc_beat_t b;
    b.sample   = smp;
    b.time_bin = tbin;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic push_window(input sample_t s [WINDOW_BINS]);
    for (int b = 0; b < WINDOW_BINS; b++) push_beat(s[b], time_bin_t'(b));
  endtask

  // Full window in bin order with random content; a shaped one carries a peak.
  task automatic queue_window(input bit shaped);
    sample_t     s [WINDOW_BINS];
    int unsigned top;
    top = ($urandom_range(0, 3) == 0) ? SAMPLE_FULL : $urandom_range(16, SAMPLE_FULL);
    foreach (s[i]) s[i] = rand_sample(top);
    if (shaped) begin
      s[3] = sample_t'($urandom_range(s[2], top));
      if ($urandom_range(0, 7) == 0) s[3] = s[2];
      if (s[3] == 0) s[3] = 1;
      s[4] = rand_sample(s[3] - 1);
    end
    push_window(s);
  endtask

  // Broken or unusual sequences between the well-formed windows.
  task automatic queue_noise();
    int      n;
    sample_t s2;
    sample_t s3;
    case ($urandom_range(0, 4))
      0: begin
        // stray beats with any bin
        repeat ($urandom_range(1, 6))
          push_beat(rand_sample(SAMPLE_FULL), time_bin_t'($urandom_range(0, WINDOW_BINS - 1)));
      end
      1: begin
        // window cut short, the next one restarts it
        n = $urandom_range(1, WINDOW_BINS - 1);
        for (int b = 0; b < n; b++) push_beat(rand_sample(SAMPLE_FULL), time_bin_t'(b));
      end
      2: begin
        // full-scale samples on repeated bins: drive the sum into saturation
        push_beat(SAMPLE_FULL, BIN_START);
        repeat ($urandom_range(7, 12))
          push_beat(SAMPLE_FULL, time_bin_t'($urandom_range(1, WINDOW_BINS - 1)));
      end
      3: begin
        // peak, then a bin 3 resent lower: flags must hold through to bin 7
        s2 = rand_sample(2000);
        s3 = s2 + sample_t'($urandom_range(1, 1000));
        push_beat(rand_sample(SAMPLE_FULL), BIN_START);
        push_beat(rand_sample(SAMPLE_FULL), time_bin_t'(1));
        push_beat(s2, BIN_REF);
        push_beat(s3, BIN_PEAK);
        push_beat(rand_sample(s3 - 1), BIN_FALL);
        push_beat(rand_sample(s3 - 1), BIN_PEAK);
        for (int b = 5; b < WINDOW_BINS; b++) push_beat(rand_sample(SAMPLE_FULL), time_bin_t'(b));
      end
      default: begin
        // bin 7 repeated after a peak keeps adding raw samples
        queue_window(1'b1);
        repeat ($urandom_range(1, 3)) push_beat(rand_sample(SAMPLE_FULL), BIN_LAST);
      end
    endcase
  endtask

  // Write one register; the block copy follows at the accepting edge.
  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= cfg_data_t'(value);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_PEDESTAL) ped_now = pedestal_t'(value);
    else gain_now = gain_t'(value);
  endtask

  // Hold until every queued beat is taken and every result beat has arrived.
  task automatic wait_drained();
    do @(posedge clk);
    while (beats_taken != beats_queued || expected_energy.size() != 0);
  endtask

  // Sample driver: launch the next pending beat once the current one is taken,
  // with a random gap now and then.
  always @(posedge clk) begin
    adc_beat_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap      <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_gap > 0) begin
        in_if.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (pending_beats.size() != 0) begin
        nxt = pending_beats.pop_front();
        in_if.valid    <= 1'b1;
        in_if.sample   <= nxt.sample;
        in_if.time_bin <= nxt.time_bin;
        in_gap         <= (idling_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure: drop ready for random stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall    <= 0;
    end else if (out_stall > 0) begin
      out_if.ready <= 1'b0;
      out_stall    <= out_stall - 1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      out_stall    <= gap_len() - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Every accepted sample beat owes exactly one energy beat.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      expected_energy.push_back(integrate_sample(in_if.sample, in_if.time_bin));
      beats_taken++;
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    energy_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_energy.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected energy beat: energy %0d valid_res %0b",
                   out_if.energy, out_if.valid_res);
      end else begin
        want = expected_energy.pop_front();
        if (out_if.energy !== want.energy || out_if.valid_res !== want.valid_res) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("energy beat mismatch: expected energy %0d valid_res %0b, got energy %0d valid_res %0b",
                     want.energy, want.valid_res, out_if.energy, out_if.valid_res);
        end
      end
    end
  end

  // Watchdog: abandon the run when no channel has moved a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("pulse_sum_peak_gain_correct_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sample_t     win [WINDOW_BINS];
    int unsigned ped_set;
    int unsigned gain_set;

    // Known values on every input from time zero; model at its reset state.
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.sample   = '0;
    in_if.time_bin = BIN_START;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_PEDESTAL;
    cfg_if.data    = '0;
    win_sum        = '0;
    win_flags      = '0;
    win_prev       = '0;
    ped_now        = '0;
    gain_now       = GAIN_UNITY;
    mismatches     = 0;
    beats_queued   = 0;
    beats_taken    = 0;
    idle_cycles    = 0;
    idling_on      = 1'b1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings (pedestal 0, unity gain).
    // A bin 7 straight after reset has no peak behind it.
    push_beat(SAMPLE_FULL, BIN_LAST);
    // All-zero window: bin 3 rises on equality but bin 4 does not fall.
    win = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
    push_window(win);
    // Near full-scale peak: a large sum that still reports.
    win = '{12'd4095, 12'd4095, 12'd4094, 12'd4095, 12'd4094, 12'd4095, 12'd4095, 12'd4095};
    push_window(win);
    // Bin 3 equal to bin 2 counts as rising; small sum.
    win = '{12'd1, 12'd2, 12'd3, 12'd3, 12'd2, 12'd1, 12'd0, 12'd0};
    push_window(win);
    // A second bin 7 keeps adding to the raw sum and reports again.
    push_beat(SAMPLE_FULL, BIN_LAST);
    wait_drained();

    // Random phases, each under its own register setting; extremes first.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          ped_set   = 0;
          gain_set  = 1023;
          idling_on = 1'b1;
        end
        1: begin
          // pedestal at or above any sum clamps to zero; zero gain; no idling
          ped_set   = 32767;
          gain_set  = 0;
          idling_on = 1'b0;
        end
        2: begin
          ped_set   = $urandom_range(0, 32767);
          gain_set  = $urandom_range(0, 1023);
          idling_on = 1'b1;
        end
        3: begin
          ped_set   = $urandom_range(0, 8000);
          gain_set  = $urandom_range(32, 200);
          idling_on = 1'b1;
        end
        default: begin
          ped_set   = 0;
          gain_set  = GAIN_UNITY;
          idling_on = 1'b1;
        end
      endcase
      write_reg(CFG_PEDESTAL, ped_set);
      write_reg(CFG_GAIN, gain_set);
      for (int w = 0; w < PHASE_WINDOWS; w++) begin
        queue_window($urandom_range(0, 9) < 6);
        if ($urandom_range(0, 3) == 0) queue_noise();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_energy.size() == 0) begin
      $display("pulse_sum_peak_gain_correct_test: done, clean");
    end else begin
      $display("pulse_sum_peak_gain_correct_test: done, errors");
    end
    $finish;
  end

endmodule

### pulse_sum_peak_gain_correct.f
rtl/psgc_pkg.sv
rtl/psgc_if.sv
rtl/pulse_sum_peak_gain_correct.sv
verif/pulse_sum_peak_gain_correct_test.sv
